// ===== src/mcomm_pkg.sv =====
// shared types and constants of the matrix commutator
`default_nettype none
package mcomm_pkg;

  localparam int MAX_DIM_DEFAULT     = 16;
  localparam int ENTRY_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS           = 16;
  localparam int MODE_W              = 2;
  localparam int INDEX_W             = 4;
  localparam int VALUE_W             = 32;
  localparam int DIM_W               = 5;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [DIM_W-1:0]  DIM_RESET        = 5'd16;
  localparam logic [MODE_W-1:0] MODE_WRITE_LEFT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY       = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE_LEFT,
    OP_WRITE_RIGHT,
    OP_QUERY,
    OP_QUERY_NULL
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/mcomm_in_if.sv =====
// input item channel of the matrix commutator
`default_nettype none
interface mcomm_in_if import mcomm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic        [MODE_W-1:0]  mode;
  logic        [INDEX_W-1:0] row;
  logic        [INDEX_W-1:0] col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink (input valid, mode, row, col, value, output ready);
endinterface
`default_nettype wire

// ===== src/mcomm_out_if.sv =====
// result item channel of the matrix commutator
`default_nettype none
interface mcomm_out_if import mcomm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] entry_value;
  logic                      saturated;

  modport source (output valid, entry_value, saturated, input ready);
  modport sink (input valid, entry_value, saturated, output ready);
endinterface
`default_nettype wire

// ===== src/matrix_commutator_top.sv =====
// top level of the matrix commutator
`default_nettype none
// Holds two square matrices L and R of signed Q16.16 entries, up to MAX_DIM by MAX_DIM,
// and answers queries for one entry of L*R - R*L over the first dim_in_use terms. Write
// items (mode 0 for L, 1 for R) store one entry and give no result; a query (mode 2)
// gives one result, truncated toward minus infinity to 16 fraction bits and saturated
// with a flag. A query at a row or column outside the matrix returns zero; mode 3 items
// are taken and dropped. Entries must be written before a query reads them. A front
// stage classifies items into a two-entry command queue so the input keeps flowing
// while the back end works. A write goes straight from the popped command into its ram.
// A query issues one multiply pair per cycle, fed by the two read ports of each
// matrix ram, into a four-stage read, multiply, subtract and accumulate pipeline and
// the saturation step. The result sits in an output register, so the next command
// starts while it waits to be taken. dim_in_use may be written only while idle.
module matrix_commutator_top import mcomm_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEFAULT,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [DIM_W-1:0] cfg_data,
  mcomm_in_if.sink              item,
  mcomm_out_if.source           result
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [DIM_W-1:0]       dim_in_use;
  logic                   push_valid;
  logic                   push_ready;
  cmd_t                   push_cmd;
  logic                   pop_valid;
  logic                   pop_ready;
  cmd_t                   pop_cmd;
  logic                   left_we;
  logic                   right_we;
  logic [ADDR_W-1:0]      waddr;
  logic [ENTRY_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]      raddr_a;
  logic [ADDR_W-1:0]      raddr_b;
  logic [ENTRY_WIDTH-1:0] left_rdata_a;
  logic [ENTRY_WIDTH-1:0] left_rdata_b;
  logic [ENTRY_WIDTH-1:0] right_rdata_a;
  logic [ENTRY_WIDTH-1:0] right_rdata_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_in_use <= DIM_RESET;
    end else if (cfg_we) begin
      dim_in_use <= cfg_data;
    end
  end

  mcomm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  mcomm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  mcomm_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_left_ram (
    .clk     (clk),
    .we      (left_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (left_rdata_a),
    .rdata_b (left_rdata_b)
  );

  mcomm_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_right_ram (
    .clk     (clk),
    .we      (right_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (right_rdata_a),
    .rdata_b (right_rdata_b)
  );

  mcomm_back #(
    .MAX_DIM     (MAX_DIM),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dim_in_use    (dim_in_use),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .left_we       (left_we),
    .right_we      (right_we),
    .waddr         (waddr),
    .wdata         (wdata),
    .raddr_a       (raddr_a),
    .raddr_b       (raddr_b),
    .left_rdata_a  (left_rdata_a),
    .left_rdata_b  (left_rdata_b),
    .right_rdata_a (right_rdata_a),
    .right_rdata_b (right_rdata_b),
    .result        (result)
  );

endmodule
`default_nettype wire

// ===== src/mcomm_ram.sv =====
// generic ram, one write port and two registered read ports
`default_nettype none
module mcomm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== src/mcomm_front.sv =====
// front end: accepts items, classifies them and registers the command
`default_nettype none
module mcomm_front import mcomm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mcomm_in_if.sink   item,
  output logic       push_valid,
  output cmd_t       push_cmd,
  input  wire logic  push_ready
);

  logic fvalid;
  cmd_t fcmd;
  logic in_range;
  logic keep;
  op_t  op;

  assign in_range = (int'(item.row) < MAX_DIM) && (int'(item.col) < MAX_DIM);

  always_comb begin
    op   = OP_QUERY_NULL;
    keep = 1'b0;
    case (item.mode)
      MODE_WRITE_LEFT: begin
        op   = OP_WRITE_LEFT;
        keep = in_range;
      end
      MODE_WRITE_RIGHT: begin
        op   = OP_WRITE_RIGHT;
        keep = in_range;
      end
      MODE_QUERY: begin
        op   = in_range ? OP_QUERY : OP_QUERY_NULL;
        keep = 1'b1;
      end
      default: begin
        // unused mode: taken and dropped
        op   = OP_QUERY_NULL;
        keep = 1'b0;
      end
    endcase
  end

  assign item.ready = !fvalid || push_ready;
  assign push_valid = fvalid;
  assign push_cmd   = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      if (fvalid && push_ready) begin
        fvalid <= 1'b0;
      end
      if (item.valid && item.ready && keep) begin
        fvalid     <= 1'b1;
        fcmd.op    <= op;
        fcmd.row   <= item.row;
        fcmd.col   <= item.col;
        fcmd.value <= item.value;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mcomm_queue.sv =====
// short command queue between front end and back end
`default_nettype none
module mcomm_queue import mcomm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire cmd_t  push_cmd,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output cmd_t       pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mcomm_back.sv =====
// back end: matrix writes and the commutator multiply-accumulate sequencer
`default_nettype none
module mcomm_back import mcomm_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEFAULT,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT,
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [DIM_W-1:0]       dim_in_use,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  input  wire cmd_t                   pop_cmd,
  output logic                        left_we,
  output logic                        right_we,
  output logic      [ADDR_W-1:0]      waddr,
  output logic      [ENTRY_WIDTH-1:0] wdata,
  output logic      [ADDR_W-1:0]      raddr_a,
  output logic      [ADDR_W-1:0]      raddr_b,
  input  wire logic [ENTRY_WIDTH-1:0] left_rdata_a,
  input  wire logic [ENTRY_WIDTH-1:0] left_rdata_b,
  input  wire logic [ENTRY_WIDTH-1:0] right_rdata_a,
  input  wire logic [ENTRY_WIDTH-1:0] right_rdata_b,
  mcomm_out_if.source                 result
);

  localparam int J_W      = $clog2(MAX_DIM);
  localparam int DCNT_W   = $clog2(MAX_DIM + 1);
  localparam int PROD_W   = 2 * ENTRY_WIDTH;
  localparam int DIFF_W   = PROD_W + 1;
  localparam int ACC_BASE = PROD_W + $clog2(MAX_DIM) + 2;
  localparam int ACC_MIN  = ENTRY_WIDTH + FRAC_BITS + 1;
  localparam int ACC_W    = (ACC_BASE > ACC_MIN) ? ACC_BASE : ACC_MIN;
  localparam int SH_W     = ACC_W - FRAC_BITS;
  localparam int UP_W     = SH_W - ENTRY_WIDTH + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                    state;
  logic        [ADDR_W-1:0]  addr_a;
  logic        [ADDR_W-1:0]  addr_b;
  logic        [J_W-1:0]     j;
  logic        [J_W-1:0]     dim_last;
  logic        [DCNT_W-1:0]  dim_eff;
  logic                      v1, v2, v3;
  logic                      last1, last2, last3;
  logic signed [PROD_W-1:0]  prod1;
  logic signed [PROD_W-1:0]  prod2;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SH_W-1:0]    sh;
  logic        [UP_W-1:0]    upper;
  logic                      fits;
  logic        [ENTRY_WIDTH-1:0] sat_val;
  logic        [ENTRY_WIDTH+VALUE_W-1:0] value_ext;
  logic        [ENTRY_WIDTH+VALUE_W-1:0] entry_ext;
  logic                      ovalid;
  logic        [ENTRY_WIDTH-1:0] oentry;
  logic                      osat;
  logic                      do_pop;
  logic                      issue_last;

  assign pop_ready  = state == S_IDLE;
  assign do_pop     = pop_valid && pop_ready;
  assign issue_last = j == dim_last;

  assign dim_eff = (int'(dim_in_use) > MAX_DIM) ? DCNT_W'(MAX_DIM) : DCNT_W'(dim_in_use);

  // writes go straight to the rams from the popped command
  assign value_ext = {{ENTRY_WIDTH{1'b0}}, pop_cmd.value};
  assign wdata     = value_ext[ENTRY_WIDTH-1:0];
  assign waddr     = ADDR_W'(int'(pop_cmd.row) * MAX_DIM + int'(pop_cmd.col));
  assign left_we   = do_pop && (pop_cmd.op == OP_WRITE_LEFT);
  assign right_we  = do_pop && (pop_cmd.op == OP_WRITE_RIGHT);

  // port a walks along the row, port b down the column
  assign raddr_a = addr_a;
  assign raddr_b = addr_b;

  // floor to the entry fraction, then saturate
  assign sh      = SH_W'(acc >>> FRAC_BITS);
  assign upper   = sh[SH_W-1:ENTRY_WIDTH-1];
  assign fits    = (&upper) || !(|upper);
  assign sat_val = acc[ACC_W-1] ? {1'b1, {(ENTRY_WIDTH-1){1'b0}}}
                                : {1'b0, {(ENTRY_WIDTH-1){1'b1}}};

  assign entry_ext          = {{VALUE_W{1'b0}}, oentry};
  assign result.valid       = ovalid;
  assign result.entry_value = entry_ext[VALUE_W-1:0];
  assign result.saturated   = osat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      v1    <= state == S_ISSUE;
      last1 <= (state == S_ISSUE) && issue_last;
      v2    <= v1;
      last2 <= last1;
      v3    <= v2;
      last3 <= last2;
      prod1 <= $signed(left_rdata_a) * $signed(right_rdata_b);
      prod2 <= $signed(right_rdata_a) * $signed(left_rdata_b);
      diff  <= DIFF_W'(prod1) - DIFF_W'(prod2);
      if (v3) begin
        acc <= acc + ACC_W'(diff);
      end
      if (ovalid && result.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (do_pop && (pop_cmd.op == OP_QUERY || pop_cmd.op == OP_QUERY_NULL)) begin
            acc      <= '0;
            addr_a   <= ADDR_W'(int'(pop_cmd.row) * MAX_DIM);
            addr_b   <= ADDR_W'(pop_cmd.col);
            j        <= '0;
            dim_last <= J_W'(dim_eff - 1'b1);
            if (pop_cmd.op == OP_QUERY && dim_eff != '0) begin
              state <= S_ISSUE;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_ISSUE: begin
          addr_a <= addr_a + 1'b1;
          addr_b <= addr_b + ADDR_W'(MAX_DIM);
          j      <= j + 1'b1;
          if (issue_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (v3 && last3) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!ovalid || result.ready) begin
            ovalid <= 1'b1;
            oentry <= fits ? sh[ENTRY_WIDTH-1:0] : sat_val;
            osat   <= !fits;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_write_when_quiet: assert property (@(posedge clk) disable iff (rst)
    (left_we || right_we) |-> (state == S_IDLE && !v1 && !v2 && !v3))
    else $error("matrix write while a query is in flight");

  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    (v3 && last3) |-> (state == S_DRAIN))
    else $error("last term arrived outside drain");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> (j <= dim_last))
    else $error("term index ran past the dimension");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!ovalid || result.ready)) |=> (ovalid && state == S_IDLE))
    else $error("result not loaded on finish");

endmodule
`default_nettype wire

// ===== dv/tb_matrix_commutator_top.sv =====
// testbench of the matrix commutator: loads L and R entries, queries commutator entries
`timescale 1ns / 100ps

module tb_matrix_commutator_top;
  import mcomm_pkg::*;

  localparam int                DIM_MAX      = MAX_DIM_DEFAULT;
  localparam int                DRAIN_CYCLES = 48;
  localparam int                STALL_LIMIT  = 2000;
  localparam int                PHASE_ITEMS  = 100;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  typedef enum {PROFILE_SMALL, PROFILE_MIXED, PROFILE_FULL, PROFILE_TINY} value_profile_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        row;
    logic [INDEX_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] entry_value;
    logic                      saturated;
  } entry_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             cfg_we   = 1'b0;
  logic [DIM_W-1:0] cfg_data = DIM_RESET;

  mcomm_in_if  item_if ();
  mcomm_out_if result_if ();

  matrix_commutator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item_if),
    .result   (result_if)
  );

  always #10 clk = ~clk;

  // shadow copy of the block state, updated on accepted items
  logic signed [VALUE_W-1:0] left_copy [DIM_MAX*DIM_MAX];
  logic signed [VALUE_W-1:0] right_copy [DIM_MAX*DIM_MAX];
  logic [DIM_W-1:0]          dim_copy = DIM_RESET;

  // entries already staged for writing, so queries never read unwritten ones
  bit left_set [DIM_MAX*DIM_MAX];
  bit right_set [DIM_MAX*DIM_MAX];

  item_t          cmd_backlog [$];
  entry_t         expected_entries [$];
  value_profile_t value_profile = PROFILE_MIXED;
  bit             in_idling     = 1'b1;
  bit             out_stalling  = 1'b1;
  int             staged_items;
  int             errors;
  int             n_checked;
  int             n_saturated;
  int             n_writes;
  int             n_ignored;

  function automatic logic signed [127:0] widen(input logic signed [VALUE_W-1:0] v);
    widen = 128'(v);
  endfunction

  function automatic entry_t commutator_entry(input int r, input int c);
    logic signed [127:0] acc;
    logic signed [127:0] lim_hi;
    logic signed [127:0] lim_lo;
    int                  terms;
    entry_t              res;
    acc    = '0;
    lim_hi = 128'(32'sh7fffffff);
    lim_lo = 128'(32'sh80000000);
    terms  = (dim_copy > DIM_MAX) ? DIM_MAX : int'(dim_copy);
    for (int j = 0; j < terms; j++) begin
      acc = acc + widen(left_copy[r*DIM_MAX+j]) * widen(right_copy[j*DIM_MAX+c])
                - widen(right_copy[r*DIM_MAX+j]) * widen(left_copy[j*DIM_MAX+c]);
    end
    // floor to 16 fraction bits
    acc = acc >>> FRAC_BITS;
    if (acc > lim_hi) begin
      res.entry_value = 32'sh7fffffff;
      res.saturated   = 1'b1;
    end else if (acc < lim_lo) begin
      res.entry_value = 32'sh80000000;
      res.saturated   = 1'b1;
    end else begin
      res.entry_value = acc[VALUE_W-1:0];
      res.saturated   = 1'b0;
    end
    return res;
  endfunction

  function automatic void apply_item(input item_t it);
    int idx;
    idx = int'(it.row) * DIM_MAX + int'(it.col);
    case (it.mode)
      MODE_WRITE_LEFT: begin
        left_copy[idx] = it.value;
        n_writes++;
      end
      MODE_WRITE_RIGHT: begin
        right_copy[idx] = it.value;
        n_writes++;
      end
      MODE_QUERY: begin
        expected_entries.push_back(commutator_entry(int'(it.row), int'(it.col)));
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  function automatic int draw_wait(input bit enabled);
    return enabled ? $urandom_range(0, 10) : 0;
  endfunction

  // driver: feeds the input channel from the backlog
  int in_gap;
  always @(posedge clk) begin : drive_items
    item_t nxt;
    if (rst) begin
      item_if.valid <= 1'b0;
      item_if.mode  <= MODE_WRITE_LEFT;
      item_if.row   <= '0;
      item_if.col   <= '0;
      item_if.value <= '0;
      in_gap        <= 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        apply_item('{item_if.mode, item_if.row, item_if.col, item_if.value});
      end
      if (!item_if.valid || item_if.ready) begin
        if (in_gap != 0) begin
          in_gap        <= in_gap - 1;
          item_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          item_if.mode  <= nxt.mode;
          item_if.row   <= nxt.row;
          item_if.col   <= nxt.col;
          item_if.value <= nxt.value;
          item_if.valid <= 1'b1;
          in_gap        <= draw_wait(in_idling);
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: takes results with random stalls and checks them in order
  int out_stall;
  always @(posedge clk) begin : check_results
    entry_t want;
    int     stall;
    if (rst) begin
      result_if.ready <= 1'b0;
      out_stall       <= 0;
    end else if (result_if.valid && result_if.ready) begin
      if (expected_entries.size() == 0) begin
        $error("unexpected result item: entry_value %0d saturated %0b",
               result_if.entry_value, result_if.saturated);
        errors++;
      end else begin
        want = expected_entries.pop_front();
        n_checked++;
        if (want.saturated) n_saturated++;
        if (result_if.entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, actual %0d", want.entry_value,
                 result_if.entry_value);
          errors++;
        end
        if (result_if.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated,
                 result_if.saturated);
          errors++;
        end
      end
      stall            = draw_wait(out_stalling);
      out_stall       <= stall;
      result_if.ready <= (stall == 0);
    end else if (out_stall != 0) begin
      out_stall       <= out_stall - 1;
      result_if.ready <= (out_stall == 1);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted item
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_matrix_commutator_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VALUE_W-1:0] draw_value();
    int pick;
    int s;
    logic signed [VALUE_W-1:0] v;
    pick = $urandom_range(0, 99);
    s    = $urandom_range(0, 32'h40000);
    v    = s - 32'h20000;
    case (value_profile)
      PROFILE_SMALL: ;
      PROFILE_TINY:  v = $urandom_range(0, 8) - 4;
      PROFILE_FULL:  v = $urandom;
      default: begin
        if (pick >= 90) begin
          v = $urandom;
        end else if (pick >= 75) begin
          case ($urandom_range(0, 5))
            0:       v = 32'sh80000000;
            1:       v = 32'sh7fffffff;
            2:       v = 32'sh00000000;
            3:       v = 32'shffffffff;
            4:       v = 32'sh00010000;
            default: v = 32'sh00000001;
          endcase
        end
      end
    endcase
    return v;
  endfunction

  task automatic push_item(input logic [MODE_W-1:0] mode, input int r, input int c,
                           input logic signed [VALUE_W-1:0] v);
    cmd_backlog.push_back('{mode, r[INDEX_W-1:0], c[INDEX_W-1:0], v});
    if (mode != MODE_IGNORED) staged_items++;
  endtask

  task automatic push_write(input logic [MODE_W-1:0] mode, input int r, input int c,
                            input logic signed [VALUE_W-1:0] v);
    if (mode == MODE_WRITE_LEFT) left_set[r*DIM_MAX+c] = 1'b1;
    else right_set[r*DIM_MAX+c] = 1'b1;
    push_item(mode, r, c, v);
  endtask

  // stage writes for every entry the query at (r, c) reads that is not yet staged, then the query
  task automatic push_query(input int r, input int c);
    int terms;
    terms = (dim_copy > DIM_MAX) ? DIM_MAX : int'(dim_copy);
    for (int j = 0; j < terms; j++) begin
      if (!left_set[r*DIM_MAX+j])  push_write(MODE_WRITE_LEFT, r, j, draw_value());
      if (!right_set[j*DIM_MAX+c]) push_write(MODE_WRITE_RIGHT, j, c, draw_value());
      if (!right_set[r*DIM_MAX+j]) push_write(MODE_WRITE_RIGHT, r, j, draw_value());
      if (!left_set[j*DIM_MAX+c])  push_write(MODE_WRITE_LEFT, j, c, draw_value());
    end
    push_item(MODE_QUERY, r, c, $urandom);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || item_if.valid || expected_entries.size() != 0);
    // writes may still sit in the command queue behind the last result
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_dim(input logic [DIM_W-1:0] d);
    wait_idle();
    dim_copy = d;
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  int             phase_dim [8]     = '{16, 31, 3, 8, 16, 5, 2, 17};
  value_profile_t phase_profile [8] = '{PROFILE_MIXED, PROFILE_FULL, PROFILE_SMALL,
                                        PROFILE_MIXED, PROFILE_SMALL, PROFILE_TINY,
                                        PROFILE_MIXED, PROFILE_MIXED};

  initial begin
    int roll;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // one term: scalars commute on the diagonal, off-diagonal extremes saturate
    set_dim(5'd1);
    push_write(MODE_WRITE_LEFT, 0, 0, 32'sh7fffffff);
    push_write(MODE_WRITE_RIGHT, 0, 0, 32'sh80000000);
    push_query(0, 0);
    push_write(MODE_WRITE_LEFT, 0, 15, 32'sh7fffffff);
    push_write(MODE_WRITE_RIGHT, 0, 15, 32'sh7fffffff);
    push_query(0, 15);
    push_write(MODE_WRITE_LEFT, 15, 0, 32'sh7fffffff);
    push_write(MODE_WRITE_RIGHT, 15, 0, 32'sh7fffffff);
    push_query(15, 0);
    push_write(MODE_WRITE_LEFT, 15, 15, 32'sh00010000);
    push_write(MODE_WRITE_RIGHT, 15, 15, 32'shffff0000);
    push_query(15, 15);
    push_item(MODE_IGNORED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);

    // empty sum
    set_dim(5'd0);
    push_query(7, 9);
    push_query(0, 0);

    // tiny entries exercise flooring of negative fractions
    set_dim(5'd2);
    value_profile = PROFILE_TINY;
    push_query(2, 3);

    for (int p = 0; p < 8; p++) begin
      set_dim(DIM_W'(phase_dim[p]));
      value_profile = phase_profile[p];
      in_idling     = (p % 3 != 2);
      out_stalling  = (p % 4 != 3);
      staged_items  = 0;
      while (staged_items < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          push_query($urandom_range(0, 15), $urandom_range(0, 15));
        end else if (roll < 93) begin
          push_write($urandom_range(0, 1) ? MODE_WRITE_RIGHT : MODE_WRITE_LEFT,
                     $urandom_range(0, 15), $urandom_range(0, 15), draw_value());
        end else begin
          push_item(MODE_IGNORED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        end
      end
    end

    wait_idle();
    $display("checked %0d commutator entries (%0d saturated) after %0d entry writes",
             n_checked, n_saturated, n_writes);
    $display("dimensions 0, 1, 2, 3, 5, 8, 16 and above; %0d mode-three items dropped",
             n_ignored);
    if (errors == 0) begin
      $display("tb_matrix_commutator_top passed");
    end else begin
      $display("tb_matrix_commutator_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mcomm_pkg.sv
src/mcomm_in_if.sv
src/mcomm_out_if.sv
src/mcomm_ram.sv
src/mcomm_front.sv
src/mcomm_queue.sv
src/mcomm_back.sv
src/matrix_commutator_top.sv
dv/tb_matrix_commutator_top.sv
